// ----- rtl/otq_pkg.sv -----
// Shared types and constants of the ordered task queue.
package otq_pkg;

    // Field widths of one beat
    localparam int OP_W     = 1;
    localparam int POS_W    = 5;
    localparam int ID_W     = 16;
    localparam int DUR_W    = 16;
    localparam int STATUS_W = 3;
    localparam int KEY_W    = 31;
    localparam int TOTAL_W  = 20;
    localparam int COUNT_W  = 5;

    // Packed stream widths (whole bytes)
    localparam int S_DATA_W = 40;
    localparam int M_DATA_W = 64;

    // Key arithmetic
    localparam logic [KEY_W-1:0] KEY_STEP = 31'd1000;
    localparam logic [KEY_W-1:0] KEY_MAX  = 31'h7FFF_FFFF;

    // Operation codes
    localparam logic [OP_W-1:0] OP_INSERT = 1'b0;
    localparam logic [OP_W-1:0] OP_REMOVE = 1'b1;

    // Result status codes
    typedef enum logic [STATUS_W-1:0] {
        STAT_OK        = 3'd0,
        STAT_BAD_POS   = 3'd1,
        STAT_EXHAUSTED = 3'd2,
        STAT_NOT_FOUND = 3'd3,
        STAT_FULL      = 3'd4,
        STAT_OVERFLOW  = 3'd5
    } status_t;

    // Controller states
    typedef enum logic [0:0] {
        S_IDLE   = 1'b0,
        S_COMMIT = 1'b1
    } state_t;

    // Commands from controller to datapath
    typedef struct packed {
        logic capture;  // take the input beat and look up the cells
        logic commit;   // update the cells and load the result register
    } otq_cmd_t;

endpackage

// ----- rtl/ordered_task_queue_with_gap_keys_core.sv -----
// An accepted input beat is captured with its lookup results, then committed to the
// cell row and the result register; the next beat is taken only after that commit.
// A new beat is taken while the previous result still waits in the output register;
// the commit holds only while that register is full and not drained.
// Reset (rst_n, async, active low) empties the list and clears the running total.
// Ordered task queue top level: controller plus cell datapath.
module ordered_task_queue_with_gap_keys_core
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                         clk,
    input  logic                         rst_n,
    // s_tdata: op[0], position[5:1], task_id[21:6], duration[37:22], zero fill
    input  logic                         s_tvalid,
    output logic                         s_tready,
    input  logic [otq_pkg::S_DATA_W-1:0] s_tdata,
    // m_tdata: status[2:0], order_key[33:3], total_duration[53:34],
    //          entry_count[58:54], zero fill
    output logic                         m_tvalid,
    input  logic                         m_tready,
    output logic [otq_pkg::M_DATA_W-1:0] m_tdata
);

    otq_pkg::otq_cmd_t cmd;

    otq_ctrl u_ctrl
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .cmd      (cmd)
    );

    otq_dpath
    #(
        .QUEUE_DEPTH (QUEUE_DEPTH)
    )
    u_dpath
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .cmd     (cmd),
        .s_tdata (s_tdata),
        .m_tdata (m_tdata)
    );

endmodule

// ----- rtl/otq_ctrl.sv -----
// Controller: input and output handshakes and command sequencing.
module otq_ctrl
(
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    output logic              m_tvalid,
    input  logic              m_tready,
    output otq_pkg::otq_cmd_t cmd
);

    otq_pkg::state_t state_reg;
    otq_pkg::state_t state_next;
    logic            out_valid_reg;
    logic            out_valid_next;
    logic            slot_free;

    // Result slot can be reloaded when empty or drained this cycle
    assign slot_free = !out_valid_reg || m_tready;

    // Next state
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            otq_pkg::S_IDLE:
            begin
                if (s_tvalid)
                begin
                    state_next = otq_pkg::S_COMMIT;
                end
            end
            otq_pkg::S_COMMIT:
            begin
                if (slot_free)
                begin
                    state_next = otq_pkg::S_IDLE;
                end
            end
            default:
            begin
                state_next = otq_pkg::S_IDLE;
            end
        endcase
    end

    // Outputs and commands
    always_comb
    begin
        s_tready    = 1'b0;
        cmd.capture = 1'b0;
        cmd.commit  = 1'b0;
        unique case (state_reg)
            otq_pkg::S_IDLE:
            begin
                s_tready    = 1'b1;
                cmd.capture = s_tvalid;
            end
            otq_pkg::S_COMMIT:
            begin
                cmd.commit = slot_free;
            end
            default:
            begin
                s_tready = 1'b0;
            end
        endcase
    end

    // Track the pending result beat
    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (cmd.commit)
        begin
            out_valid_next = 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_next = 1'b0;
        end
    end

    assign m_tvalid = out_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= otq_pkg::S_IDLE;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            out_valid_reg <= out_valid_next;
        end
    end

endmodule

// ----- rtl/otq_dpath.sv -----
// Datapath: row of task cells, lookup, key arithmetic and result register.
module otq_dpath
#(
    parameter int QUEUE_DEPTH = 16
)
(
    input  logic                          clk,
    input  logic                          rst_n,
    input  otq_pkg::otq_cmd_t             cmd,
    input  logic [otq_pkg::S_DATA_W-1:0]  s_tdata,
    output logic [otq_pkg::M_DATA_W-1:0]  m_tdata
);

    localparam int CW    = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W = CW + otq_pkg::POS_W;
    localparam int SUM_W = otq_pkg::DUR_W + CW;
    localparam int KW    = otq_pkg::KEY_W;

    // Input beat fields
    logic [otq_pkg::OP_W-1:0]  in_op;
    logic [otq_pkg::POS_W-1:0] in_pos;
    logic [otq_pkg::ID_W-1:0]  in_id;
    logic [otq_pkg::DUR_W-1:0] in_dur;

    assign in_op  = s_tdata[0];
    assign in_pos = s_tdata[5:1];
    assign in_id  = s_tdata[21:6];
    assign in_dur = s_tdata[37:22];

    // Task cells
    logic [otq_pkg::ID_W-1:0]  id_reg   [QUEUE_DEPTH];
    logic [KW-1:0]             key_reg  [QUEUE_DEPTH];
    logic [otq_pkg::DUR_W-1:0] dur_reg  [QUEUE_DEPTH];
    logic [otq_pkg::ID_W-1:0]  id_next  [QUEUE_DEPTH];
    logic [KW-1:0]             key_next [QUEUE_DEPTH];
    logic [otq_pkg::DUR_W-1:0] dur_next [QUEUE_DEPTH];

    logic [CW-1:0]    count_reg;
    logic [CW-1:0]    count_next;
    logic [SUM_W-1:0] sum_reg;
    logic [SUM_W-1:0] sum_next;

    // Captured item and lookup results
    logic [otq_pkg::OP_W-1:0]  op_reg;
    logic [otq_pkg::POS_W-1:0] pos_reg;
    logic [otq_pkg::ID_W-1:0]  tid_reg;
    logic [otq_pkg::DUR_W-1:0] tdur_reg;
    logic [KW-1:0]             prev_key_reg;
    logic [KW-1:0]             next_key_reg;
    logic [KW-1:0]             last_key_reg;
    logic                      found_reg;
    logic [otq_pkg::DUR_W-1:0] hit_dur_reg;
    logic [QUEUE_DEPTH-1:0]    from_hit_reg;

    logic [KW-1:0]             prev_key_c;
    logic [KW-1:0]             next_key_c;
    logic [KW-1:0]             last_key_c;
    logic [otq_pkg::DUR_W-1:0] hit_dur_c;
    logic [QUEUE_DEPTH-1:0]    match_c;
    logic [QUEUE_DEPTH-1:0]    from_hit_c;
    logic [CMP_W-1:0]          in_pos_w;
    logic [CMP_W-1:0]          cnt_w;

    // Result register
    otq_pkg::status_t              res_status_reg;
    logic [KW-1:0]                 res_key_reg;
    logic [otq_pkg::TOTAL_W-1:0]   res_total_reg;
    logic [otq_pkg::COUNT_W-1:0]   res_count_reg;

    // Commit arithmetic
    otq_pkg::status_t          status_c;
    logic [KW-1:0]             new_key_c;
    logic [CMP_W-1:0]          pos_w;
    logic [KW:0]               pair_sum;
    logic [KW-1:0]             mid_key;
    logic                      apply_ins;
    logic                      apply_rem;
    logic [SUM_W+otq_pkg::TOTAL_W-1:0] sum_ext;
    logic [CW+otq_pkg::COUNT_W-1:0]    cnt_ext;

    assign in_pos_w = {{CW{1'b0}}, in_pos};
    assign cnt_w    = {{otq_pkg::POS_W{1'b0}}, count_reg};

    // Look up neighbor keys and the first id match
    always_comb
    begin
        prev_key_c = '0;
        next_key_c = '0;
        last_key_c = '0;
        hit_dur_c  = '0;
        match_c    = '0;
        from_hit_c = '0;
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            if (CMP_W'(i + 1) == in_pos_w)
            begin
                prev_key_c = prev_key_c | key_reg[i];
            end
            if (CMP_W'(i) == in_pos_w)
            begin
                next_key_c = next_key_c | key_reg[i];
            end
            if (CMP_W'(i + 1) == cnt_w)
            begin
                last_key_c = last_key_c | key_reg[i];
            end
            match_c[i] = (id_reg[i] == in_id) && (CMP_W'(i) < cnt_w);
        end
        from_hit_c[0] = match_c[0];
        if (match_c[0])
        begin
            hit_dur_c = dur_reg[0];
        end
        for (int i = 1; i < QUEUE_DEPTH; i++)
        begin
            from_hit_c[i] = from_hit_c[i-1] | match_c[i];
            if (match_c[i] && !from_hit_c[i-1])
            begin
                hit_dur_c = hit_dur_c | dur_reg[i];
            end
        end
    end

    // Capture the beat and lookup results
    always_ff @(posedge clk)
    begin
        if (cmd.capture)
        begin
            op_reg       <= in_op;
            pos_reg      <= in_pos;
            tid_reg      <= in_id;
            tdur_reg     <= in_dur;
            prev_key_reg <= prev_key_c;
            next_key_reg <= next_key_c;
            last_key_reg <= last_key_c;
            found_reg    <= from_hit_c[QUEUE_DEPTH-1];
            hit_dur_reg  <= hit_dur_c;
            from_hit_reg <= from_hit_c;
        end
    end

    // Work out status and key of the captured item
    assign pos_w    = {{CW{1'b0}}, pos_reg};
    assign pair_sum = {1'b0, prev_key_reg} + {1'b0, next_key_reg};
    assign mid_key  = pair_sum[KW:1];

    always_comb
    begin
        status_c  = otq_pkg::STAT_OK;
        new_key_c = '0;
        if (op_reg == otq_pkg::OP_REMOVE)
        begin
            if (!found_reg)
            begin
                status_c = otq_pkg::STAT_NOT_FOUND;
            end
        end
        else if (pos_w > cnt_w)
        begin
            status_c = otq_pkg::STAT_BAD_POS;
        end
        else if (cnt_w >= CMP_W'(QUEUE_DEPTH))
        begin
            status_c = otq_pkg::STAT_FULL;
        end
        else if (count_reg == '0)
        begin
            new_key_c = otq_pkg::KEY_STEP;
        end
        else if (pos_w == cnt_w)
        begin
            if (last_key_reg > (otq_pkg::KEY_MAX - otq_pkg::KEY_STEP))
            begin
                status_c = otq_pkg::STAT_OVERFLOW;
            end
            else
            begin
                new_key_c = last_key_reg + otq_pkg::KEY_STEP;
            end
        end
        else if (pos_reg == '0)
        begin
            if (key_reg[0] == '0)
            begin
                status_c = otq_pkg::STAT_EXHAUSTED;
            end
            else
            begin
                new_key_c = {1'b0, key_reg[0][KW-1:1]};
            end
        end
        else if (mid_key == prev_key_reg)
        begin
            status_c = otq_pkg::STAT_EXHAUSTED;
        end
        else
        begin
            new_key_c = mid_key;
        end
    end

    assign apply_ins = (op_reg == otq_pkg::OP_INSERT) && (status_c == otq_pkg::STAT_OK);
    assign apply_rem = (op_reg == otq_pkg::OP_REMOVE) && (status_c == otq_pkg::STAT_OK);

    // Shift cells open on insert, closed on remove
    always_comb
    begin
        for (int i = 0; i < QUEUE_DEPTH; i++)
        begin
            id_next[i]  = id_reg[i];
            key_next[i] = key_reg[i];
            dur_next[i] = dur_reg[i];
            if (apply_ins)
            begin
                if (CMP_W'(i) == pos_w)
                begin
                    id_next[i]  = tid_reg;
                    key_next[i] = new_key_c;
                    dur_next[i] = tdur_reg;
                end
                else if ((CMP_W'(i) > pos_w) && (i > 0))
                begin
                    id_next[i]  = id_reg[i-1];
                    key_next[i] = key_reg[i-1];
                    dur_next[i] = dur_reg[i-1];
                end
            end
            else if (apply_rem && from_hit_reg[i] && (i < QUEUE_DEPTH - 1))
            begin
                id_next[i]  = id_reg[i+1];
                key_next[i] = key_reg[i+1];
                dur_next[i] = dur_reg[i+1];
            end
        end
    end

    // Count and running total
    always_comb
    begin
        count_next = count_reg;
        sum_next   = sum_reg;
        if (apply_ins)
        begin
            count_next = count_reg + CW'(1);
            sum_next   = sum_reg + {{CW{1'b0}}, tdur_reg};
        end
        else if (apply_rem)
        begin
            count_next = count_reg - CW'(1);
            sum_next   = sum_reg - {{CW{1'b0}}, hit_dur_reg};
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            for (int i = 0; i < QUEUE_DEPTH; i++)
            begin
                id_reg[i]  <= id_next[i];
                key_reg[i] <= key_next[i];
                dur_reg[i] <= dur_next[i];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            sum_reg   <= '0;
        end
        else if (cmd.commit)
        begin
            count_reg <= count_next;
            sum_reg   <= sum_next;
        end
    end

    // Load the result beat
    assign sum_ext = {{otq_pkg::TOTAL_W{1'b0}}, sum_next};
    assign cnt_ext = {{otq_pkg::COUNT_W{1'b0}}, count_next};

    always_ff @(posedge clk)
    begin
        if (cmd.commit)
        begin
            res_status_reg <= status_c;
            res_key_reg    <= new_key_c;
            res_total_reg  <= sum_ext[otq_pkg::TOTAL_W-1:0];
            res_count_reg  <= cnt_ext[otq_pkg::COUNT_W-1:0];
        end
    end

    assign m_tdata = {5'd0, res_count_reg, res_total_reg, res_key_reg, res_status_reg};

endmodule

// ----- test/tb.sv -----
// Stream testbench for the ordered task queue core: directed cases, then random traffic.
`timescale 1ns / 100ps

module tb;

    localparam int DEPTH        = 16;
    localparam int RANDOM_ITEMS = 950;
    localparam int BURST_ITEMS  = 150;
    localparam int CYCLE_LIMIT  = 600000;

    // One request to the queue
    typedef struct packed {
        logic [otq_pkg::OP_W-1:0]  op;
        logic [otq_pkg::POS_W-1:0] pos;
        logic [otq_pkg::ID_W-1:0]  id;
        logic [otq_pkg::DUR_W-1:0] dur;
    } task_req_t;

    // One reply from the queue
    typedef struct {
        otq_pkg::status_t            status;
        logic [otq_pkg::KEY_W-1:0]   key;
        logic [otq_pkg::TOTAL_W-1:0] total;
        logic [otq_pkg::COUNT_W-1:0] count;
    } queue_reply_t;

    logic                         clk;
    logic                         rst_n;
    logic                         s_tvalid;
    logic                         s_tready;
    logic [otq_pkg::S_DATA_W-1:0] s_tdata;
    logic                         m_tvalid;
    logic                         m_tready;
    logic [otq_pkg::M_DATA_W-1:0] m_tdata;

    // Shadow copy of the task list
    logic [otq_pkg::ID_W-1:0]  task_ids  [DEPTH];
    logic [otq_pkg::KEY_W-1:0] task_keys [DEPTH];
    logic [otq_pkg::DUR_W-1:0] task_durs [DEPTH];
    int                        n_tasks;
    logic [31:0]               dur_total;

    queue_reply_t expected_replies [$];
    int           error_count;
    int           cycle_count;
    bit           no_idle;

    ordered_task_queue_with_gap_keys_core #(
        .QUEUE_DEPTH (DEPTH)
    ) u_top (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Abort a hung run
    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: failure");
            $finish;
        end
    end

    // Idle length: mostly none or short, a few long
    function automatic int idle_len();
        int r;
        r = $urandom_range(0, 99);
        if (no_idle || r < 50)
            return 0;
        else if (r < 85)
            return $urandom_range(1, 3);
        else if (r < 97)
            return $urandom_range(4, 10);
        else
            return $urandom_range(11, 40);
    endfunction

    // Apply one request to the shadow list and return the reply it gives
    function automatic queue_reply_t apply_queue_op(input task_req_t req);
        queue_reply_t              r;
        logic [otq_pkg::KEY_W-1:0] new_key;
        logic [otq_pkg::KEY_W:0]   mid_sum;
        int                        p;
        int                        hit;
        r.status = otq_pkg::STAT_OK;
        r.key    = '0;
        new_key  = '0;
        p        = int'(req.pos);
        hit      = -1;
        if (req.op == otq_pkg::OP_INSERT)
        begin
            // Position check comes before the full check
            if (p > n_tasks)
                r.status = otq_pkg::STAT_BAD_POS;
            else if (n_tasks >= DEPTH)
                r.status = otq_pkg::STAT_FULL;
            else if (n_tasks == 0)
                new_key = otq_pkg::KEY_STEP;
            else if (p == n_tasks)
            begin
                if (task_keys[n_tasks-1] > otq_pkg::KEY_MAX - otq_pkg::KEY_STEP)
                    r.status = otq_pkg::STAT_OVERFLOW;
                else
                    new_key = task_keys[n_tasks-1] + otq_pkg::KEY_STEP;
            end
            else if (p == 0)
            begin
                if (task_keys[0] == '0)
                    r.status = otq_pkg::STAT_EXHAUSTED;
                else
                    new_key = task_keys[0] >> 1;
            end
            else
            begin
                // Midpoint on one extra bit so the sum cannot wrap
                mid_sum = {1'b0, task_keys[p-1]} + {1'b0, task_keys[p]};
                new_key = mid_sum[otq_pkg::KEY_W:1];
                if (new_key == task_keys[p-1])
                    r.status = otq_pkg::STAT_EXHAUSTED;
            end
            if (r.status == otq_pkg::STAT_OK)
            begin
                for (int i = n_tasks; i > p; i--)
                begin
                    task_ids[i]  = task_ids[i-1];
                    task_keys[i] = task_keys[i-1];
                    task_durs[i] = task_durs[i-1];
                end
                task_ids[p]  = req.id;
                task_keys[p] = new_key;
                task_durs[p] = req.dur;
                n_tasks++;
                dur_total += 32'(req.dur);
                r.key = new_key;
            end
        end
        else
        begin
            // Take the match nearest the head
            for (int i = 0; i < n_tasks; i++)
                if (hit < 0 && task_ids[i] == req.id)
                    hit = i;
            if (hit < 0)
                r.status = otq_pkg::STAT_NOT_FOUND;
            else
            begin
                dur_total -= 32'(task_durs[hit]);
                for (int i = hit; i + 1 < n_tasks; i++)
                begin
                    task_ids[i]  = task_ids[i+1];
                    task_keys[i] = task_keys[i+1];
                    task_durs[i] = task_durs[i+1];
                end
                n_tasks--;
            end
        end
        r.total = dur_total[otq_pkg::TOTAL_W-1:0];
        r.count = n_tasks[otq_pkg::COUNT_W-1:0];
        return r;
    endfunction

    task automatic report_mismatch(input string what, input logic [31:0] got,
                                   input logic [31:0] want);
        $display("tb: mismatch in %s: got %0d, want %0d (t=%0t)", what, got, want, $realtime);
        error_count++;
    endtask

    // Drive one beat, wait for the handshake, then idle for a random gap, possibly none
    task automatic send_item(input logic [otq_pkg::OP_W-1:0] op, input int pos,
                             input logic [otq_pkg::ID_W-1:0] id,
                             input logic [otq_pkg::DUR_W-1:0] dur);
        task_req_t req;
        int        gap;
        req.op  = op;
        req.pos = pos[otq_pkg::POS_W-1:0];
        req.id  = id;
        req.dur = dur;
        @(negedge clk);
        s_tdata        = '0;
        s_tdata[0]     = req.op;
        s_tdata[5:1]   = req.pos;
        s_tdata[21:6]  = req.id;
        s_tdata[37:22] = req.dur;
        s_tvalid       = 1'b1;
        do
            @(posedge clk);
        while (!s_tready);
        expected_replies.push_back(apply_queue_op(req));
        gap = idle_len();
        if (gap > 0)
        begin
            @(negedge clk);
            s_tvalid = 1'b0;
            s_tdata  = otq_pkg::S_DATA_W'({$urandom, $urandom});
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    // Receiver: stall for random stretches
    initial
    begin : ready_gen
        int stall_left;
        stall_left = 0;
        m_tready   = 1'b0;
        forever
        begin
            @(negedge clk);
            if (stall_left > 0)
            begin
                m_tready = 1'b0;
                stall_left--;
            end
            else
            begin
                m_tready = 1'b1;
                if ($urandom_range(0, 99) < 30)
                    stall_left = idle_len();
            end
        end
    end

    // Compare each result beat with the oldest pending reply
    always @(posedge clk)
    begin
        queue_reply_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (expected_replies.size() == 0)
                report_mismatch("unexpected result beat", m_tdata[31:0], 32'd0);
            else
            begin
                want = expected_replies.pop_front();
                if (m_tdata[2:0] !== want.status)
                    report_mismatch("status", 32'(m_tdata[2:0]), 32'(want.status));
                if (m_tdata[33:3] !== want.key)
                    report_mismatch("order_key", 32'(m_tdata[33:3]), 32'(want.key));
                if (m_tdata[53:34] !== want.total)
                    report_mismatch("total_duration", 32'(m_tdata[53:34]),
                                    32'(want.total));
                if (m_tdata[58:54] !== want.count)
                    report_mismatch("entry_count", 32'(m_tdata[58:54]),
                                    32'(want.count));
            end
        end
    end

    // Random request shaped by the current list contents
    task automatic send_random(input bit grow);
        logic [otq_pkg::OP_W-1:0]  op;
        logic [otq_pkg::ID_W-1:0]  id;
        logic [otq_pkg::DUR_W-1:0] dur;
        int                        pos;
        int                        r;
        op = ($urandom_range(0, 99) < (grow ? 75 : 25)) ? otq_pkg::OP_INSERT
                                                        : otq_pkg::OP_REMOVE;
        r  = $urandom_range(0, 99);
        if (r < 10)
            pos = 0;
        else if (r < 25)
            pos = n_tasks;
        else if (r < 88)
            pos = $urandom_range(0, n_tasks);
        else
            pos = $urandom_range(n_tasks, 31);
        r = $urandom_range(0, 99);
        if (r < 40 && n_tasks > 0)
            id = task_ids[$urandom_range(0, n_tasks - 1)];
        else if (r < 65)
            id = otq_pkg::ID_W'($urandom_range(0, 7));
        else if (r < 75)
            id = ($urandom_range(0, 1) != 0) ? 16'hFFFF : 16'h0000;
        else
            id = otq_pkg::ID_W'($urandom);
        r = $urandom_range(0, 99);
        if (r < 8)
            dur = '0;
        else if (r < 16)
            dur = '1;
        else
            dur = otq_pkg::DUR_W'($urandom);
        send_item(op, pos, id, dur);
    endtask

    // Empty list: remove misses, bad positions, first insert gets the base key
    task automatic test_empty_list();
        send_item(otq_pkg::OP_REMOVE, 0, 16'h1234, 16'h0000);
        send_item(otq_pkg::OP_INSERT, 1, 16'h0001, 16'h0001);
        send_item(otq_pkg::OP_INSERT, 31, 16'hFFFF, 16'hFFFF);
        send_item(otq_pkg::OP_INSERT, 0, 16'h0000, 16'h0000);
    endtask

    // Tail and middle keys
    task automatic test_tail_middle();
        send_item(otq_pkg::OP_INSERT, 1, 16'hFFFF, 16'hFFFF);
        send_item(otq_pkg::OP_INSERT, 1, 16'h0002, 16'h8000);
    endtask

    // Halve the head key down to zero, then hit both exhausted cases
    task automatic test_key_exhaustion();
        for (int k = 0; k < 10; k++)
            send_item(otq_pkg::OP_INSERT, 0, 16'(16'h0100 + k), 16'(16'h0010 * k));
        send_item(otq_pkg::OP_INSERT, 0, 16'h0200, 16'h0200);
        // Keys 0 and 1 at the head leave no room between them
        send_item(otq_pkg::OP_INSERT, 1, 16'h0201, 16'h0201);
    endtask

    // Fill with duplicate ids, hit full and bad position, remove duplicates
    task automatic test_full_and_duplicates();
        send_item(otq_pkg::OP_INSERT, n_tasks, 16'h00AA, 16'h1111);
        send_item(otq_pkg::OP_INSERT, n_tasks, 16'h00AA, 16'h2222);
        send_item(otq_pkg::OP_INSERT, n_tasks, 16'h00AA, 16'h3333);
        send_item(otq_pkg::OP_INSERT, 0, 16'h0300, 16'h0300);
        send_item(otq_pkg::OP_INSERT, 16, 16'h0301, 16'h0301);
        send_item(otq_pkg::OP_INSERT, 17, 16'h0302, 16'h0302);
        send_item(otq_pkg::OP_REMOVE, 0, 16'h00AA, 16'hFFFF);
        send_item(otq_pkg::OP_REMOVE, 31, 16'h00AA, 16'h0000);
    endtask

    // Random traffic in grow and shrink phases
    // (tail key overflow needs millions of tail inserts and is out of reach here)
    task automatic test_random_traffic(input int n);
        bit grow;
        grow = 1'b1;
        for (int k = 0; k < n; k++)
        begin
            if (k % 40 == 0)
                grow = ($urandom_range(0, 1) != 0);
            send_random(grow);
        end
    endtask

    // Random traffic with no idling on either side
    task automatic test_back_to_back(input int n);
        no_idle = 1'b1;
        test_random_traffic(n);
        no_idle = 1'b0;
    endtask

    initial
    begin
        rst_n       = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        n_tasks     = 0;
        dur_total   = '0;
        error_count = 0;
        cycle_count = 0;
        no_idle     = 1'b0;
        repeat (12) @(negedge clk);
        rst_n = 1'b1;

        test_empty_list();
        test_tail_middle();
        test_key_exhaustion();
        test_full_and_duplicates();
        test_random_traffic(RANDOM_ITEMS / 2);
        test_back_to_back(BURST_ITEMS);
        test_random_traffic(RANDOM_ITEMS - RANDOM_ITEMS / 2 - BURST_ITEMS);

        // Drain outstanding results
        @(negedge clk);
        s_tvalid = 1'b0;
        while (expected_replies.size() != 0)
            @(posedge clk);
        repeat (8) @(posedge clk);

        if (error_count == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule
